[hdl/atan2_pkg.sv]
// Shared widths, payload types and fixed-point constants of the atan2 pipeline.
package atan2_pkg;

    localparam int IN_WIDTH        = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

    // Internal fraction bits, magnitude, ratio, accumulator and product widths
    localparam int WF     = 30;
    localparam int MAG_W  = IN_WIDTH + 1;
    localparam int Q_W    = WF + 1;
    localparam int ACC_W  = 34;
    localparam int PROD_W = (ACC_W - 1) + Q_W;
    localparam int SHIFT  = WF - ANGLE_FRAC_BITS;
    localparam int NCOEF  = 6;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] x_value;
        logic signed [IN_WIDTH-1:0] y_value;
    } in_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] angle;
        logic                          undefined;
    } out_t;

    // Quadrant and octant flags carried beside the data
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic swap;
        logic zero;
    } side_t;

    localparam longint ONE_Q = longint'(1) << WF;

    // Minimax coefficients in signed Q4.30, highest power first
    localparam logic signed [ACC_W-1:0] POLY_COEF [NCOEF] = '{
        ACC_W'(-((longint'(13480470)  * ONE_Q + 500000000) / 1000000000)),
        ACC_W'( ((longint'(57477314)  * ONE_Q + 500000000) / 1000000000)),
        ACC_W'(-((longint'(121239071) * ONE_Q + 500000000) / 1000000000)),
        ACC_W'( ((longint'(195635925) * ONE_Q + 500000000) / 1000000000)),
        ACC_W'(-((longint'(332994597) * ONE_Q + 500000000) / 1000000000)),
        ACC_W'( ((longint'(999995630) * ONE_Q + 500000000) / 1000000000))
    };

    localparam logic signed [ACC_W-1:0] HALF_PI_Q =
        ACC_W'((longint'(1570796327) * ONE_Q + 500000000) / 1000000000);
    localparam logic signed [ACC_W-1:0] PI_Q =
        ACC_W'((longint'(64'd3141592654) * ONE_Q + 500000000) / 1000000000);
    localparam logic [ACC_W-1:0] PI_OUT =
        ACC_W'(((longint'(64'd3141592654) * ONE_Q + 500000000) / 1000000000
                + (longint'(1) << (SHIFT - 1))) >> SHIFT);

endpackage

[hdl/atan2_odd_polynomial.sv]
// Top level: fully pipelined four-quadrant arctangent with an odd polynomial.
//
// One (x, y) transfer is taken in every cycle; busy never rises. Each result
// appears on result for one cycle with done high, after passing through
// one input stage, 31 stages of a restoring divider that forms the ratio one
// quotient bit per stage, one squaring stage, six multiply and round/add stage
// pairs for the Horner steps and the final multiply by the ratio, one
// reflection stage and one output rounding stage. The receiver cannot stall
// the pipeline, so results must be taken as they come. Both inputs zero give
// angle 0 with undefined set.
module atan2_odd_polynomial
    import atan2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  operands,
    output logic done,
    output out_t result
);

    // Pipeline never stalls
    assign busy = 1'b0;

    // ---------------- input stage: magnitudes and flags ----------------
    logic             in_valid_reg;
    logic [MAG_W-1:0] in_hi_reg, in_lo_reg;
    side_t            in_side_reg;

    logic [MAG_W-1:0] ax_next, ay_next;
    logic [MAG_W-1:0] xe, ye;

    always_comb
    begin
        xe = {operands.x_value[IN_WIDTH-1], operands.x_value};
        ye = {operands.y_value[IN_WIDTH-1], operands.y_value};
        ax_next = operands.x_value[IN_WIDTH-1] ? MAG_W'(-xe) : xe;
        ay_next = operands.y_value[IN_WIDTH-1] ? MAG_W'(-ye) : ye;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_hi_reg        <= (ax_next > ay_next) ? ax_next : ay_next;
        in_lo_reg        <= (ax_next > ay_next) ? ay_next : ax_next;
        in_side_reg.xneg <= operands.x_value[IN_WIDTH-1];
        in_side_reg.yneg <= operands.y_value[IN_WIDTH-1];
        in_side_reg.swap <= ay_next > ax_next;
        in_side_reg.zero <= (ax_next == '0) && (ay_next == '0);
    end

    // ---------------- divider: one quotient bit per stage ----------------
    logic             dv_valid_reg [Q_W+1];
    logic [MAG_W-1:0] dv_rem_reg   [Q_W+1];
    logic [MAG_W-1:0] dv_hi_reg    [Q_W+1];
    logic [Q_W-1:0]   dv_quo_reg   [Q_W+1];
    side_t            dv_side_reg  [Q_W+1];

    assign dv_valid_reg[0] = in_valid_reg;
    assign dv_rem_reg[0]   = in_lo_reg;
    assign dv_hi_reg[0]    = in_hi_reg;
    assign dv_quo_reg[0]   = '0;
    assign dv_side_reg[0]  = in_side_reg;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        logic [MAG_W:0]   trial;
        logic             qbit;
        logic [MAG_W-1:0] rem_next;

        // The first step compares lo itself; later steps shift the remainder
        if (k == 0)
        begin : g_first
            assign trial = {1'b0, dv_rem_reg[k]};
        end
        else
        begin : g_rest
            assign trial = {dv_rem_reg[k], 1'b0};
        end

        assign qbit     = trial >= {1'b0, dv_hi_reg[k]};
        assign rem_next = qbit ? MAG_W'(trial - {1'b0, dv_hi_reg[k]}) : MAG_W'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[k+1]  <= rem_next;
            dv_hi_reg[k+1]   <= dv_hi_reg[k];
            dv_quo_reg[k+1]  <= {dv_quo_reg[k][Q_W-2:0], qbit};
            dv_side_reg[k+1] <= dv_side_reg[k];
        end
    end

    // ---------------- square of the ratio ----------------
    logic           sq_valid_reg;
    logic [Q_W-1:0] sq_t_reg, sq_t2_reg;
    side_t          sq_side_reg;
    logic [2*Q_W-1:0] sq_prod;

    assign sq_prod = (2*Q_W)'(dv_quo_reg[Q_W]) * (2*Q_W)'(dv_quo_reg[Q_W])
                   + (2*Q_W)'(longint'(1) << (WF - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else
            sq_valid_reg <= dv_valid_reg[Q_W];
    end

    always_ff @(posedge clk)
    begin
        sq_t_reg    <= dv_quo_reg[Q_W];
        sq_t2_reg   <= sq_prod[WF+Q_W-1:WF];
        sq_side_reg <= dv_side_reg[Q_W];
    end

    // ---------------- Horner steps, then the final multiply by t ----------------
    logic                    mu_valid_reg [NCOEF];
    logic [PROD_W-1:0]       mu_prod_reg  [NCOEF];
    logic                    mu_neg_reg   [NCOEF];
    logic [Q_W-1:0]          mu_t_reg     [NCOEF];
    logic [Q_W-1:0]          mu_t2_reg    [NCOEF];
    side_t                   mu_side_reg  [NCOEF];

    logic                    ad_valid_reg [NCOEF];
    logic signed [ACC_W-1:0] ad_acc_reg   [NCOEF];
    logic [Q_W-1:0]          ad_t_reg     [NCOEF];
    logic [Q_W-1:0]          ad_t2_reg    [NCOEF];
    side_t                   ad_side_reg  [NCOEF];

    for (genvar j = 0; j < NCOEF; j++)
    begin : g_horner
        logic                    src_valid;
        logic signed [ACC_W-1:0] src_acc;
        logic [Q_W-1:0]          src_t, src_t2, factor;
        side_t                   src_side;
        logic [ACC_W-2:0]        acc_mag;
        logic signed [ACC_W-1:0] addend;
        logic [PROD_W-1:0]       rounded;
        logic signed [ACC_W-1:0] prod_s;

        if (j == 0)
        begin : g_src0
            assign src_valid = sq_valid_reg;
            assign src_acc   = POLY_COEF[0];
            assign src_t     = sq_t_reg;
            assign src_t2    = sq_t2_reg;
            assign src_side  = sq_side_reg;
        end
        else
        begin : g_srcn
            assign src_valid = ad_valid_reg[j-1];
            assign src_acc   = ad_acc_reg[j-1];
            assign src_t     = ad_t_reg[j-1];
            assign src_t2    = ad_t2_reg[j-1];
            assign src_side  = ad_side_reg[j-1];
        end

        // Horner steps scale by t^2 and add the next coefficient; the last scales by t
        if (j < NCOEF - 1)
        begin : g_step
            assign factor = src_t2;
            assign addend = POLY_COEF[j+1];
        end
        else
        begin : g_last
            assign factor = src_t;
            assign addend = '0;
        end

        assign acc_mag = src_acc[ACC_W-1] ? (ACC_W-1)'(-src_acc) : (ACC_W-1)'(src_acc);

        // Multiply stage: magnitude times factor
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                mu_valid_reg[j] <= 1'b0;
            else
                mu_valid_reg[j] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            mu_prod_reg[j] <= PROD_W'(acc_mag) * PROD_W'(factor);
            mu_neg_reg[j]  <= src_acc[ACC_W-1];
            mu_t_reg[j]    <= src_t;
            mu_t2_reg[j]   <= src_t2;
            mu_side_reg[j] <= src_side;
        end

        // Round half away from zero, restore sign, add coefficient
        assign rounded = mu_prod_reg[j] + PROD_W'(longint'(1) << (WF - 1));
        assign prod_s  = mu_neg_reg[j] ? -ACC_W'(rounded[PROD_W-1:WF])
                                       :  ACC_W'(rounded[PROD_W-1:WF]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ad_valid_reg[j] <= 1'b0;
            else
                ad_valid_reg[j] <= mu_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            ad_acc_reg[j]  <= prod_s + addend;
            ad_t_reg[j]    <= mu_t_reg[j];
            ad_t2_reg[j]   <= mu_t2_reg[j];
            ad_side_reg[j] <= mu_side_reg[j];
        end
    end

    // ---------------- reflection into the right octant and quadrant ----------------
    logic                    rf_valid_reg;
    logic signed [ACC_W-1:0] rf_angle_reg;
    logic                    rf_zero_reg;
    logic signed [ACC_W-1:0] a1, a2, a3;

    always_comb
    begin
        a1 = ad_side_reg[NCOEF-1].swap ? HALF_PI_Q - ad_acc_reg[NCOEF-1] : ad_acc_reg[NCOEF-1];
        a2 = ad_side_reg[NCOEF-1].xneg ? PI_Q - a1 : a1;
        a3 = ad_side_reg[NCOEF-1].yneg ? -a2 : a2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rf_valid_reg <= 1'b0;
        else
            rf_valid_reg <= ad_valid_reg[NCOEF-1];
    end

    always_ff @(posedge clk)
    begin
        rf_angle_reg <= a3;
        rf_zero_reg  <= ad_side_reg[NCOEF-1].zero;
    end

    // ---------------- output rounding and saturation ----------------
    logic             done_reg;
    out_t             result_reg;
    logic [ACC_W-1:0] out_mag, out_rnd, out_sat;
    out_t             result_next;

    always_comb
    begin
        out_mag = rf_angle_reg[ACC_W-1] ? ACC_W'(-rf_angle_reg) : ACC_W'(rf_angle_reg);
        out_rnd = (out_mag + ACC_W'(longint'(1) << (SHIFT - 1))) >> SHIFT;
        out_sat = (out_rnd > PI_OUT) ? PI_OUT : out_rnd;
        if (rf_zero_reg)
        begin
            result_next.angle     = '0;
            result_next.undefined = 1'b1;
        end
        else
        begin
            result_next.angle     = rf_angle_reg[ACC_W-1] ? -ANGLE_WIDTH'(out_sat)
                                                          :  ANGLE_WIDTH'(out_sat);
            result_next.undefined = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rf_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions ----------------
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.undefined |-> result.angle == '0)
        else $error("undefined result with nonzero angle");

    a_angle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.angle <= $signed(ANGLE_WIDTH'(PI_OUT)))
              && (result.angle >= -$signed(ANGLE_WIDTH'(PI_OUT))))
        else $error("angle beyond pi");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(rf_valid_reg))
        else $error("result without an item in the last stage");

endmodule

[tb/atan2_odd_polynomial_tb.sv]
// Testbench for the atan2 odd-polynomial pipeline: directed corners, random pairs, idle phases.
module atan2_odd_polynomial_tb;
    import atan2_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 47;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  operands;
    logic done;
    out_t result;

    out_t   angle_queue[$];
    int     error_count;
    int     sent_count;
    int     checked_count;
    longint cycle_count;
    int     send_idle_pct;

    atan2_odd_polynomial dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    // Generate clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Multiply a signed value by an unsigned Q1.30 factor, round half away from zero
    function automatic longint scale_q30(longint a, longint b);
        logic   neg;
        longint mag;
        longint p;
        neg = a < 0;
        mag = neg ? -a : a;
        p = (mag * b + (longint'(1) << (WF - 1))) >>> WF;
        return neg ? -p : p;
    endfunction

    // Compute the expected angle of one (x, y) pair
    function automatic out_t predict_angle(in_t op);
        out_t   r;
        longint ax;
        longint ay;
        longint hi;
        longint lo;
        longint t;
        longint t2;
        longint acc;
        longint a;
        longint mag;
        longint pi_lim;
        logic   neg;
        ax = op.x_value < 0 ? -longint'(op.x_value) : longint'(op.x_value);
        ay = op.y_value < 0 ? -longint'(op.y_value) : longint'(op.y_value);
        hi = ax > ay ? ax : ay;
        lo = ax > ay ? ay : ax;
        r = '0;
        if (hi == 0)
        begin
            r.undefined = 1'b1;
            return r;
        end
        t = (lo << WF) / hi;
        t2 = (t * t + (longint'(1) << (WF - 1))) >>> WF;
        acc = longint'(POLY_COEF[0]);
        for (int i = 1; i < NCOEF; i++)
            acc = scale_q30(acc, t2) + longint'(POLY_COEF[i]);
        a = scale_q30(acc, t);
        if (ay > ax)
            a = longint'(HALF_PI_Q) - a;
        if (op.x_value < 0)
            a = longint'(PI_Q) - a;
        if (op.y_value < 0)
            a = -a;
        neg = a < 0;
        mag = neg ? -a : a;
        mag = (mag + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
        pi_lim = (longint'(PI_Q) + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
        if (mag > pi_lim)
            mag = pi_lim;
        if (neg)
            mag = -mag;
        r.angle = mag[ANGLE_WIDTH-1:0];
        return r;
    endfunction

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (angle_queue.size() == 0)
            begin
                $error("result with nothing expected: angle %0d undefined %0b",
                       result.angle, result.undefined);
                error_count++;
            end
            else
            begin
                want = angle_queue.pop_front();
                checked_count++;
                if (result.angle !== want.angle)
                begin
                    $error("angle: expected %0d, actual %0d", want.angle, result.angle);
                    error_count++;
                end
                if (result.undefined !== want.undefined)
                begin
                    $error("undefined: expected %0b, actual %0b",
                           want.undefined, result.undefined);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Send one pair, with random idle cycles ahead of it; start stays high
    // until the next pair or a drain lowers it
    task automatic send_pair(logic signed [IN_WIDTH-1:0] x, logic signed [IN_WIDTH-1:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        operands.x_value <= x;
        operands.y_value <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        angle_queue.push_back(predict_angle('{x_value: x, y_value: y}));
        sent_count++;
        @(negedge clk);
    endtask

    // Hold until every expected result has arrived
    task automatic drain_results();
        start <= 1'b0;
        while (angle_queue.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_corners();
        logic signed [IN_WIDTH-1:0] big;
        logic signed [IN_WIDTH-1:0] neg_big;
        big = 16'sh7fff;
        neg_big = 16'sh8000;
        send_pair(0, 0);
        send_pair(0, 1);
        send_pair(0, -1);
        send_pair(1, 0);
        send_pair(-1, 0);
        send_pair(-5, 0);
        send_pair(100, 100);
        send_pair(-100, 100);
        send_pair(-100, -100);
        send_pair(100, -100);
        send_pair(big, big);
        send_pair(neg_big, neg_big);
        send_pair(neg_big, 0);
        send_pair(0, neg_big);
        send_pair(neg_big, big);
        send_pair(big, neg_big);
        send_pair(big, 1);
        send_pair(1, big);
        send_pair(neg_big, -1);
        send_pair(-1, neg_big);
        send_pair(neg_big, 1);
        send_pair(3, 7);
        send_pair(-7, 3);
    endtask

    // Random pairs: full range, small values, near-diagonal and axis-adjacent
    task automatic test_random(int count);
        logic signed [IN_WIDTH-1:0] x;
        logic signed [IN_WIDTH-1:0] y;
        for (int i = 0; i < count; i++)
        begin
            x = IN_WIDTH'($urandom);
            y = IN_WIDTH'($urandom);
            case ($urandom_range(3))
                0: ;
                1:
                begin
                    x = IN_WIDTH'($urandom_range(8) - 4);
                    y = IN_WIDTH'($urandom_range(8) - 4);
                end
                2: y = IN_WIDTH'(($urandom_range(1) ? x : -x) + $urandom_range(2) - 1);
                default: y = IN_WIDTH'($urandom_range(2) - 1);
            endcase
            send_pair(x, y);
        end
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;
        test_random(600);
        send_idle_pct = 75;
        test_random(300);
        drain_results();
        send_idle_pct = 6;
        test_random(400);
        send_idle_pct = 0;
        test_random(425);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operands = '0;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_corners();
        test_idle_phases();
        drain_results();
        repeat (LATENCY + 10) @(negedge clk);
        $display("sent %0d pairs, checked %0d angles over all quadrants and idle mixes",
                 sent_count, checked_count);
        if (error_count == 0 && angle_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
